// ----- hw/rtl/char_raster_draw_engine_assert.svh -----
// assertion macros for the character raster draw engine
`ifndef CHAR_RASTER_DRAW_ENGINE_ASSERT_SVH
`define CHAR_RASTER_DRAW_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define CRDE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crde assertion failed");
`define CRDE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crde assertion failed");
`else
`define CRDE_ASSERT_IMPL(label, ante, cons)
`define CRDE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/crde_pkg.sv -----
// shared types and constants of the character raster draw engine
package crde_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 32;
   localparam int CELLS    = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int PROD_W   = 16;

   localparam logic [7:0]  SPACE_CODE = 8'd32;
   localparam logic [11:0] COUNT_MAX  = 12'd4095;
   localparam logic [17:0] RING_SLACK = 18'd3;
   localparam logic [7:0]  COL_LAST   = 8'(MAX_COLS - 1);
   localparam logic [7:0]  ROW_LAST   = 8'(MAX_ROWS - 1);

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      FUNC_CLEAR = 3'd0,
      FUNC_POINT = 3'd1,
      FUNC_LINE  = 3'd2,
      FUNC_RECT  = 3'd3,
      FUNC_FILL  = 3'd4,
      FUNC_CIRC  = 3'd5,
      FUNC_DISC  = 3'd6,
      FUNC_READ  = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      JOB_NONE = 2'd0,
      JOB_BOX  = 2'd1,
      JOB_CIRC = 2'd2,
      JOB_LINE = 2'd3
   } job_kind_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] start_x;
      logic [7:0] start_y;
      logic [7:0] end_x;
      logic [7:0] end_y;
      logic [7:0] radius;
      logic [7:0] fill_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_char;
      logic [11:0] cells_written;
   } rsp_type;

   typedef struct packed {
      logic       boot;
      logic       load_item;
      logic       setup;
      logic [1:0] job_idx;
      logic       scan_step;
      logic       circ_sq;
      logic       circ_cmp;
      logic       line_mul;
      logic       div_start;
      logic       line_write;
      logic       read_issue;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      func_type     func;
      job_kind_type setup_kind;
      logic         setup_empty;
      logic         last;
      logic         div_busy;
      logic         div_done;
      logic         rsp_free;
      logic         mem_wr;
   } stat_type;

endpackage

// ----- hw/rtl/crde_div.sv -----
// restoring divider, one quotient bit per cycle
module crde_div
   import crde_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [7:0]        divisor,
   output logic              busy,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [7:0]        rem_ff, rem_in;
   logic [8:0]        shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(PROD_W);
         quo_in = dividend;
         rem_in = 8'd0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
         if (shifted >= {1'b0, divisor}) begin
            rem_in = 8'(shifted - {1'b0, divisor});
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[7:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/crde_dpath.sv -----
// datapath: frame store, scan counters, circle test, line interpolation, result register
module crde_dpath
   import crde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata,
   input  logic       rsp_stall,
   output stat_type   stat,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   logic [6:0]   width_ff, width_in;
   logic [5:0]   height_ff, height_in;
   req_type      item_ff;
   logic [15:0]  r2_ff;
   job_kind_type kind_ff;
   logic         space_ff;
   logic [7:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [7:0]   x_lo_ff, x_hi_ff, y_hi_ff;
   logic [7:0]   ln_x2_ff, ln_y2_ff, ln_a_ff, ln_d_ff;
   logic         ln_neg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [15:0]  dx_sq_ff, dy_sq_ff;
   logic [11:0]  count_ff;
   logic [7:0]   rd_data_ff;
   logic         rd_ok_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;
   logic [7:0]   frame_ff [CELLS];

   logic [8:0]   eff_w, eff_h, lim_w, lim_h;
   job_kind_type s_kind;
   logic         s_clip;
   logic [7:0]   bx_lo, bx_hi, by_lo, by_hi, bx_hi_c, by_hi_c;
   logic         x_empty, y_empty;
   logic [7:0]   minx, maxx, miny, maxy;
   logic [7:0]   dxm, dym;
   logic [16:0]  dist_sum;
   logic         hit;
   logic [7:0]   lx, mag;
   logic         x_ok;
   logic         wr_en;
   logic [7:0]   wr_x;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic         rd_in;
   logic         div_busy, div_done;
   logic [PROD_W-1:0] quotient;
   logic         adv;

   crde_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (ln_d_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      eff_w = ({2'b0, width_ff} < 9'(MAX_COLS)) ? {2'b0, width_ff} : 9'(MAX_COLS);
      eff_h = ({3'b0, height_ff} < 9'(MAX_ROWS)) ? {3'b0, height_ff} : 9'(MAX_ROWS);
   end

   // job limits for the current command and outline side
   always_comb begin
      minx   = (item_ff.start_x < item_ff.end_x) ? item_ff.start_x : item_ff.end_x;
      maxx   = (item_ff.start_x < item_ff.end_x) ? item_ff.end_x : item_ff.start_x;
      miny   = (item_ff.start_y < item_ff.end_y) ? item_ff.start_y : item_ff.end_y;
      maxy   = (item_ff.start_y < item_ff.end_y) ? item_ff.end_y : item_ff.start_y;
      s_kind = JOB_NONE;
      s_clip = 1'b1;
      bx_lo  = 8'd0;
      bx_hi  = 8'd0;
      by_lo  = 8'd0;
      by_hi  = 8'd0;
      if (cmd.boot) begin
         s_kind = JOB_BOX;
         s_clip = 1'b0;
         bx_hi  = COL_LAST;
         by_hi  = ROW_LAST;
      end else begin
         case (item_ff.func)
            FUNC_CLEAR: begin
               s_kind = JOB_BOX;
               s_clip = 1'b0;
               bx_hi  = COL_LAST;
               by_hi  = ROW_LAST;
            end
            FUNC_POINT: begin
               s_kind = JOB_BOX;
               bx_lo  = item_ff.start_x;
               bx_hi  = item_ff.start_x;
               by_lo  = item_ff.start_y;
               by_hi  = item_ff.start_y;
            end
            FUNC_LINE: begin
               by_lo = miny;
               by_hi = maxy;
               if (item_ff.start_y == item_ff.end_y) begin
                  s_kind = JOB_BOX;
                  bx_lo  = minx;
                  bx_hi  = maxx;
               end else begin
                  s_kind = JOB_LINE;
               end
            end
            FUNC_RECT: begin
               s_kind = JOB_BOX;
               case (cmd.job_idx)
                  2'd0: begin
                     bx_lo = item_ff.start_x;
                     bx_hi = item_ff.start_x;
                     by_lo = miny;
                     by_hi = maxy;
                  end
                  2'd1: begin
                     bx_lo = minx;
                     bx_hi = maxx;
                     by_lo = item_ff.end_y;
                     by_hi = item_ff.end_y;
                  end
                  2'd2: begin
                     bx_lo = minx;
                     bx_hi = maxx;
                     by_lo = item_ff.start_y;
                     by_hi = item_ff.start_y;
                  end
                  default: begin
                     bx_lo = item_ff.end_x;
                     bx_hi = item_ff.end_x;
                     by_lo = miny;
                     by_hi = maxy;
                  end
               endcase
            end
            FUNC_FILL: begin
               s_kind = JOB_BOX;
               bx_lo  = item_ff.start_x;
               bx_hi  = item_ff.end_x;
               by_lo  = item_ff.start_y;
               by_hi  = item_ff.end_y;
            end
            FUNC_CIRC, FUNC_DISC: begin
               s_kind = JOB_CIRC;
               bx_hi  = 8'hFF;
               by_hi  = 8'hFF;
            end
            default: s_kind = JOB_NONE;
         endcase
      end
      lim_w   = s_clip ? eff_w : 9'(MAX_COLS);
      lim_h   = s_clip ? eff_h : 9'(MAX_ROWS);
      x_empty = (bx_lo > bx_hi) || ({1'b0, bx_lo} >= lim_w);
      y_empty = (by_lo > by_hi) || ({1'b0, by_lo} >= lim_h);
      bx_hi_c = ({1'b0, bx_hi} >= lim_w) ? 8'(lim_w - 9'd1) : bx_hi;
      by_hi_c = ({1'b0, by_hi} >= lim_h) ? 8'(lim_h - 9'd1) : by_hi;
   end

   // circle membership from the registered squares
   always_comb begin
      dxm  = (cx_ff >= item_ff.start_x) ? cx_ff - item_ff.start_x : item_ff.start_x - cx_ff;
      dym  = (cy_ff >= item_ff.start_y) ? cy_ff - item_ff.start_y : item_ff.start_y - cy_ff;
      dist_sum = {1'b0, dx_sq_ff} + {1'b0, dy_sq_ff};
      if (item_ff.func == FUNC_DISC) begin
         hit = (dist_sum <= {1'b0, r2_ff});
      end else begin
         hit = (({1'b0, dist_sum} + RING_SLACK) > {2'b0, r2_ff}) &&
               ({1'b0, dist_sum} < ({2'b0, r2_ff} + RING_SLACK));
      end
   end

   // column of a sloped line, truncated toward zero
   always_comb begin
      mag  = quotient[7:0];
      lx   = ln_neg_ff ? ln_x2_ff + mag : ln_x2_ff - mag;
      x_ok = ({1'b0, lx} < eff_w);
   end

   always_comb begin
      wr_en   = cmd.scan_step || (cmd.circ_cmp && hit) || (cmd.line_write && x_ok);
      wr_x    = cmd.line_write ? lx : cx_ff;
      wr_addr = ADDR_W'(16'(cy_ff) * 16'(MAX_COLS) + 16'(wr_x));
      rd_in   = ({1'b0, item_ff.start_x} < eff_w) && ({1'b0, item_ff.start_y} < eff_h);
      rd_addr = rd_in ? ADDR_W'(16'(item_ff.start_y) * 16'(MAX_COLS) + 16'(item_ff.start_x))
                      : '0;
      adv     = cmd.scan_step || cmd.circ_cmp || cmd.line_write;
   end

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (cmd.setup) begin
         cx_in = bx_lo;
         cy_in = by_lo;
      end else if (adv) begin
         if (kind_ff == JOB_LINE) begin
            cy_in = cy_ff + 8'd1;
         end else if (cx_ff == x_hi_ff) begin
            cx_in = x_lo_ff;
            cy_in = cy_ff + 8'd1;
         end else begin
            cx_in = cx_ff + 8'd1;
         end
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         if (csr_index == CSR_WIDTH) width_in = csr_wdata;
         else height_in = csr_wdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 7'd64;
         height_ff    <= 6'd32;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= JOB_NONE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.setup) kind_ff <= s_kind;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      if (cmd.load_item) begin
         item_ff  <= req_data;
         r2_ff    <= req_data.radius * req_data.radius;
         count_ff <= 12'd0;
         rd_ok_ff <= 1'b0;
      end else if (wr_en && (count_ff != COUNT_MAX)) begin
         count_ff <= count_ff + 12'd1;
      end
      if (cmd.setup) begin
         space_ff  <= cmd.boot || (item_ff.func == FUNC_CLEAR);
         x_lo_ff   <= bx_lo;
         x_hi_ff   <= bx_hi_c;
         y_hi_ff   <= by_hi_c;
         ln_y2_ff  <= maxy;
         ln_d_ff   <= maxy - miny;
         if (item_ff.start_y < item_ff.end_y) begin
            ln_x2_ff  <= item_ff.end_x;
            ln_neg_ff <= (item_ff.start_x > item_ff.end_x);
         end else begin
            ln_x2_ff  <= item_ff.start_x;
            ln_neg_ff <= (item_ff.end_x > item_ff.start_x);
         end
         ln_a_ff <= maxx - minx;
      end
      if (cmd.line_mul) prod_ff <= ln_a_ff * (ln_y2_ff - cy_ff);
      if (cmd.circ_sq) begin
         dx_sq_ff <= dxm * dxm;
         dy_sq_ff <= dym * dym;
      end
      if (cmd.read_issue) rd_ok_ff <= rd_in;
      if (cmd.load_rsp) begin
         rsp_data_ff.read_char     <= rd_ok_ff ? rd_data_ff : 8'd0;
         rsp_data_ff.cells_written <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) frame_ff[wr_addr] <= space_ff ? SPACE_CODE : item_ff.fill_char;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) rd_data_ff <= frame_ff[rd_addr];
   end

   always_comb begin
      stat.func        = item_ff.func;
      stat.setup_kind  = s_kind;
      stat.setup_empty = y_empty || ((s_kind != JOB_LINE) && x_empty);
      stat.last        = (kind_ff == JOB_LINE) ? (cy_ff == y_hi_ff)
                                               : ((cx_ff == x_hi_ff) && (cy_ff == y_hi_ff));
      stat.div_busy    = div_busy;
      stat.div_done    = div_done;
      stat.rsp_free    = !rsp_valid_ff || !rsp_stall;
      stat.mem_wr      = wr_en;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/crde_ctrl.sv -----
// controller state machine sequencing the draw jobs
module crde_ctrl
   import crde_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     req_stall,
   output cmd_type  cmd
);

   typedef enum logic [11:0] {
      ST_BOOT  = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_SETUP = 12'b000000000100,
      ST_SCAN  = 12'b000000001000,
      ST_CSQ   = 12'b000000010000,
      ST_CCMP  = 12'b000000100000,
      ST_LMUL  = 12'b000001000000,
      ST_LDST  = 12'b000010000000,
      ST_LDIV  = 12'b000100000000,
      ST_LWR   = 12'b001000000000,
      ST_READ  = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       boot_ff, boot_in;
   logic [1:0] job_ff, job_in;
   state_type  fin_state;
   logic [1:0] fin_job;

   // where to go once a job runs out
   always_comb begin
      fin_job = job_ff;
      if (boot_ff) begin
         fin_state = ST_IDLE;
      end else if ((stat.func == FUNC_RECT) && (job_ff != 2'd3)) begin
         fin_state = ST_SETUP;
         fin_job   = job_ff + 2'd1;
      end else begin
         fin_state = ST_DONE;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      boot_in  = boot_ff;
      job_in   = job_ff;
      cmd.job_idx = job_ff;
      case (state_ff)
         ST_BOOT: begin
            cmd.setup = 1'b1;
            cmd.boot  = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               job_in        = 2'd0;
               state_in      = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (stat.func == FUNC_READ) begin
               state_in = ST_READ;
            end else if (stat.setup_empty) begin
               state_in = fin_state;
               job_in   = fin_job;
            end else begin
               case (stat.setup_kind)
                  JOB_BOX:  state_in = ST_SCAN;
                  JOB_CIRC: state_in = ST_CSQ;
                  JOB_LINE: state_in = ST_LMUL;
                  default: begin
                     state_in = fin_state;
                     job_in   = fin_job;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last) begin
               state_in = fin_state;
               job_in   = fin_job;
               boot_in  = 1'b0;
            end
         end
         ST_CSQ: begin
            cmd.circ_sq = 1'b1;
            state_in    = ST_CCMP;
         end
         ST_CCMP: begin
            cmd.circ_cmp = 1'b1;
            if (stat.last) begin
               state_in = fin_state;
               job_in   = fin_job;
            end else begin
               state_in = ST_CSQ;
            end
         end
         ST_LMUL: begin
            cmd.line_mul = 1'b1;
            state_in     = ST_LDST;
         end
         ST_LDST: begin
            cmd.div_start = 1'b1;
            state_in      = ST_LDIV;
         end
         ST_LDIV: begin
            if (stat.div_done) state_in = ST_LWR;
         end
         ST_LWR: begin
            cmd.line_write = 1'b1;
            if (stat.last) begin
               state_in = fin_state;
               job_in   = fin_job;
            end else begin
               state_in = ST_LMUL;
            end
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         boot_ff  <= 1'b1;
         job_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
         job_ff   <= job_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- hw/rtl/char_raster_draw_engine.sv -----
// Character raster draw engine: a 64 x 32 store of 8-bit character cells that takes one
// drawing command per beat (clear, point, line, rectangle outline or fill, circle outline
// or fill, read) and returns one result beat with the cell read and the number of cell
// writes made. After reset the store is swept to space, one cell per cycle; no command is
// taken during the sweep, register writes are. The single write port of the store sets
// the pace: clear sweeps the whole store, points, spans and rectangle fills write each
// clipped cell in turn, circles visit each cell of the width times height in use
// (squaring then compare), and sloped lines go row by row (multiply, then a 16-step
// divider for the column, then the write). Each command passes through setup and
// result hand-off; a finished result waits in an output register while the next
// command is taken.
`include "char_raster_draw_engine_assert.svh"
module char_raster_draw_engine
   import crde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   crde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   crde_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `CRDE_ASSERT_IMPL(a_div_free, cmd.div_start, !stat.div_busy)
   `CRDE_ASSERT_IMPL(a_no_write_idle, !req_stall, !stat.mem_wr)
   `CRDE_ASSERT_IMPL(a_rsp_slot, cmd.load_rsp, stat.rsp_free)
   `CRDE_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall)

endmodule
